// File: rtl/pcf_pkg.sv
// Package for the PNG chunk framer: phase codes, byte kinds, the item record
// and the byte-wide reflected CRC-32 fold.
// No dependencies.
`default_nettype none

package pcf_pkg;

  localparam int unsigned DataW   = 8;
  localparam int unsigned LenW    = 31;
  localparam int unsigned CrcW    = 32;
  localparam int unsigned InTdataW  = 40;
  localparam int unsigned OutTuserW = 3;

  localparam logic [CrcW-1:0] CrcPreset = 32'hFFFF_FFFF;
  localparam logic [CrcW-1:0] CrcPoly   = 32'hEDB8_8320;

  // Kind of an emitted word.
  typedef enum logic [1:0] {
    KIND_LEN  = 2'd0,
    KIND_DATA = 2'd1,
    KIND_CRC  = 2'd2
  } byte_kind_e;

  // Position of the emitter within the words one item causes.
  typedef enum logic [3:0] {
    PH_LEN3 = 4'd0,
    PH_LEN2 = 4'd1,
    PH_LEN1 = 4'd2,
    PH_LEN0 = 4'd3,
    PH_DATA = 4'd4,
    PH_CRC3 = 4'd5,
    PH_CRC2 = 4'd6,
    PH_CRC1 = 4'd7,
    PH_CRC0 = 4'd8
  } phase_e;

  // One accepted item with its finished CRC.
  typedef struct packed {
    logic [DataW-1:0] data_byte;
    logic [LenW-1:0]  data_length;
    logic             first_byte;
    logic             last_byte;
    logic [CrcW-1:0]  crc_fin;
  } item_t;

  // Fold one byte into a reflected CRC-32, eight shift steps.
  function automatic logic [CrcW-1:0] crc_fold(input logic [CrcW-1:0] crc,
                                              input logic [DataW-1:0] b);
    logic [CrcW-1:0] c;
    c = crc ^ {{(CrcW-DataW){1'b0}}, b};
    for (int i = 0; i < DataW; i++) begin
      c = c[0] ? (CrcPoly ^ (c >> 1)) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// File: rtl/pcf_crc.sv
// Running CRC-32 register of the chunk framer.
// Depends on pcf_pkg for the fold function and constants.
`default_nettype none

module pcf_crc
  import pcf_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             accept_i,
  input  wire logic [DataW-1:0] data_byte_i,
  input  wire logic             first_byte_i,
  input  wire logic             last_byte_i,
  output logic      [CrcW-1:0]  crc_fin_o
);

  logic [CrcW-1:0] crc_q, crc_d;
  logic [CrcW-1:0] crc_next;

  // A first byte restarts the CRC before the byte is folded in.
  always_comb begin
    crc_next  = crc_fold(first_byte_i ? CrcPreset : crc_q, data_byte_i);
    crc_fin_o = ~crc_next;
    crc_d     = crc_q;
    if (accept_i) begin
      crc_d = last_byte_i ? CrcPreset : crc_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q <= CrcPreset;
    end else begin
      crc_q <= crc_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/pcf_emitter.sv
// Item slot, word sequencer and output register of the chunk framer.
// Depends on pcf_pkg for the item record, phase codes and byte kinds.
`default_nettype none

module pcf_emitter
  import pcf_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire item_t            in_item_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic      [DataW-1:0] out_byte_o,
  output byte_kind_e            out_kind_o,
  output logic                  out_last_o,
  output logic                  out_done_o
);

  logic       item_valid_q, item_valid_d;
  item_t      item_q, item_d;
  phase_e     phase_q, phase_d;

  logic       out_valid_q, out_valid_d;
  logic [DataW-1:0] out_byte_q, out_byte_d;
  byte_kind_e out_kind_q, out_kind_d;
  logic       out_last_q, out_last_d;
  logic       out_done_q, out_done_d;

  logic       out_load, emit, emit_last, accept;
  phase_e     end_phase;
  logic [CrcW-1:0] len32;
  logic [DataW-1:0] sel_byte;
  byte_kind_e sel_kind;

  // Handshake between slot and output register.
  always_comb begin
    out_load   = !out_valid_q || out_ready_i;
    emit       = item_valid_q && out_load;
    end_phase  = item_q.last_byte ? PH_CRC0 : PH_DATA;
    emit_last  = emit && (phase_q == end_phase);
    in_ready_o = !item_valid_q || emit_last;
    accept     = in_valid_i && in_ready_o;
  end

  // Word selection for the current phase.
  always_comb begin
    len32 = {1'b0, item_q.data_length};
    unique case (phase_q)
      PH_LEN3: begin sel_byte = len32[31:24];          sel_kind = KIND_LEN;  end
      PH_LEN2: begin sel_byte = len32[23:16];          sel_kind = KIND_LEN;  end
      PH_LEN1: begin sel_byte = len32[15:8];           sel_kind = KIND_LEN;  end
      PH_LEN0: begin sel_byte = len32[7:0];            sel_kind = KIND_LEN;  end
      PH_CRC3: begin sel_byte = item_q.crc_fin[31:24]; sel_kind = KIND_CRC;  end
      PH_CRC2: begin sel_byte = item_q.crc_fin[23:16]; sel_kind = KIND_CRC;  end
      PH_CRC1: begin sel_byte = item_q.crc_fin[15:8];  sel_kind = KIND_CRC;  end
      PH_CRC0: begin sel_byte = item_q.crc_fin[7:0];   sel_kind = KIND_CRC;  end
      default: begin sel_byte = item_q.data_byte;      sel_kind = KIND_DATA; end
    endcase
  end

  // Slot and phase update.
  always_comb begin
    item_valid_d = item_valid_q;
    item_d       = item_q;
    phase_d      = phase_q;
    if (accept) begin
      item_valid_d = 1'b1;
      item_d       = in_item_i;
      phase_d      = in_item_i.first_byte ? PH_LEN3 : PH_DATA;
    end else if (emit_last) begin
      item_valid_d = 1'b0;
    end else if (emit) begin
      phase_d = phase_e'(phase_q + 4'd1);
    end
  end

  // Output register loads whenever it is empty or being drained.
  always_comb begin
    out_valid_d = out_valid_q;
    out_byte_d  = out_byte_q;
    out_kind_d  = out_kind_q;
    out_last_d  = out_last_q;
    out_done_d  = out_done_q;
    if (out_load) begin
      out_valid_d = emit;
    end
    if (emit) begin
      out_byte_d = sel_byte;
      out_kind_d = sel_kind;
      out_last_d = phase_q == end_phase;
      out_done_d = phase_q == PH_CRC0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
      phase_q      <= PH_DATA;
      out_valid_q  <= 1'b0;
    end else begin
      item_valid_q <= item_valid_d;
      phase_q      <= phase_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q     <= item_d;
    out_byte_q <= out_byte_d;
    out_kind_q <= out_kind_d;
    out_last_q <= out_last_d;
    out_done_q <= out_done_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_kind_o  = out_kind_q;
  assign out_last_o  = out_last_q;
  assign out_done_o  = out_done_q;

  // The final CRC word always closes the run.
  a_done_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_done_q |-> out_last_q && (out_kind_q == KIND_CRC))
    else $error("chunk_done without end of run on a CRC word");

  // The phase never runs past the item's final word.
  a_phase_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_valid_q |-> (phase_q <= end_phase))
    else $error("emitter phase beyond end of item");

  // An item is not dropped before its final word leaves.
  a_slot_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit && !emit_last |=> item_valid_q)
    else $error("item slot emptied before final word");

endmodule

`default_nettype wire

// File: rtl/png_chunk_framer_crc32.sv
// Path: an item is held in the item slot; its words leave through the output register.
// Throughput: one item per cycle for plain bytes when not stalled; a first byte adds four
// length words and a last byte four CRC words, one word per cycle when not stalled.
// The item slot takes the next item in the cycle its final word moves out.
// Reset: asynchronous, active low; clears valids and presets the CRC to all ones.
// Top level of the PNG chunk framer; depends on pcf_pkg, pcf_crc and pcf_emitter.
`default_nettype none

module png_chunk_framer_crc32
  import pcf_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  input  wire logic [InTdataW-1:0]    s_axis_tdata_i,  // data_byte[7:0], data_length[38:8]
  input  wire logic                   s_axis_tlast_i,  // last_byte
  input  wire logic                   s_axis_tuser_i,  // first_byte
  output logic                        m_axis_tvalid_o,
  input  wire logic                   m_axis_tready_i,
  output logic      [DataW-1:0]       m_axis_tdata_o,  // out_byte[7:0]
  output logic                        m_axis_tlast_o,  // end_of_run
  output logic      [OutTuserW-1:0]   m_axis_tuser_o   // byte_kind[1:0], chunk_done[2]
);

  logic            accept;
  logic [CrcW-1:0] crc_fin;
  item_t           in_item;
  byte_kind_e      out_kind;
  logic            out_done;

  assign accept = s_axis_tvalid_i && s_axis_tready_o;

  // CRC is folded as the word is accepted.
  pcf_crc u_crc (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .data_byte_i  (s_axis_tdata_i[7:0]),
    .first_byte_i (s_axis_tuser_i),
    .last_byte_i  (s_axis_tlast_i),
    .crc_fin_o    (crc_fin)
  );

  // Gather the accepted item.
  always_comb begin
    in_item.data_byte   = s_axis_tdata_i[7:0];
    in_item.data_length = s_axis_tdata_i[38:8];
    in_item.first_byte  = s_axis_tuser_i;
    in_item.last_byte   = s_axis_tlast_i;
    in_item.crc_fin     = crc_fin;
  end

  pcf_emitter u_emitter (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_item_i   (in_item),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_byte_o  (m_axis_tdata_o),
    .out_kind_o  (out_kind),
    .out_last_o  (m_axis_tlast_o),
    .out_done_o  (out_done)
  );

  assign m_axis_tuser_o = {out_done, out_kind};

endmodule

`default_nettype wire
